### rtl/core/bfs_pkg.sv
// bfs_pkg: shared constants, FSM state type and queue interface structs
// for the breadth-first search unit. No dependencies.
`timescale 1ns / 1ps

package bfs_pkg;

  localparam int MAX_NODES = 8;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int PTR_W     = $clog2(MAX_NODES + 1);
  localparam int CNT_W     = 4;
  localparam int ROW_W     = 8;

  localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 4'd7;
  localparam logic [CNT_W-1:0]  MAX_NODES_CNT  = CNT_W'(MAX_NODES);
  localparam logic [NODE_W-1:0] LAST_COL       = NODE_W'(ROW_W - 1);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN
  } bfs_state_t;

  typedef struct packed {
    logic              clear;
    logic              push;
    logic              pop;
    logic [NODE_W-1:0] push_data;
  } q_ctl_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [NODE_W-1:0] head_data;
  } q_sts_t;

endpackage

### rtl/core/bfs_adjacency_matrix_unit.sv
// bfs_adjacency_matrix_unit: top level of the breadth-first search unit.
// Depends on bfs_pkg and bfs_queue.
`timescale 1ns / 1ps
//
//  Channel   Handshake                   Payload
//  -------   -------------------------   -------------------------------------
//  input     start & !busy               in_func, in_row_index, in_row_bits,
//                                        in_start_node
//  result    out_valid (one-cycle pulse) out_visit_node, out_last
//  config    cfg_valid & cfg_ready       cfg_node_count
//
//  A row load, like a start node outside the node count, leaves the unit idle.
//  A traversal handles each dequeued node in the fetch state and then scans
//  all eight adjacency bits of its row in the scan state, since one
//  compare unit checks one adjacency bit per cycle.
//  Results are pulsed with no backpressure. Each result leaves one node
//  behind the scan, so the final transaction (out_last) sits on the result
//  ports in the first cycle after busy drops, which may also accept a new
//  input transaction.
//  Reset clears the FSM, the adjacency rows, the queue pointers and sets the
//  node count to 7; the queue store itself is not cleared.

module bfs_adjacency_matrix_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [2:0]                  in_row_index,
  input  logic [7:0]                  in_row_bits,
  input  logic [2:0]                  in_start_node,
  // result channel
  output logic                        out_valid,
  output logic [2:0]                  out_visit_node,
  output logic                        out_last,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bfs_pkg::CNT_W-1:0]   cfg_node_count
);
  import bfs_pkg::*;

  bfs_state_t        state_r, state_nxt;

  logic [CNT_W-1:0]  node_count_r;
  logic [ROW_W-1:0]  adj_r [MAX_NODES];
  logic [ROW_W-1:0]  row_r;
  logic [NODE_W-1:0] col_r;
  logic [ROW_W-1:0]  visited_r;
  logic [NODE_W-1:0] pend_node_r;

  logic              out_valid_r;
  logic [NODE_W-1:0] out_visit_node_r;
  logic              out_last_r;

  q_ctl_t            q_ctl;
  q_sts_t            q_sts;

  logic              in_fire;
  logic [CNT_W-1:0]  n_eff;
  logic              start_ok;
  logic              hit;

  // control strobes from the output decoder
  logic              seed;
  logic              load_row;
  logic              fetch;
  logic              emit;
  logic              emit_last;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = ~busy;
  assign in_fire   = start & ~busy;

  // node_count above the array size acts as the array size
  assign n_eff    = (node_count_r > MAX_NODES_CNT) ? MAX_NODES_CNT : node_count_r;
  assign start_ok = ({1'b0, in_start_node} < n_eff);

  // shared compare unit: one neighbor column per cycle
  assign hit = ({1'b0, col_r} < n_eff) && row_r[col_r] && !visited_r[col_r]
               && !q_sts.full;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_func == FUNC_START && start_ok) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = q_sts.empty ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (col_r == LAST_COL) state_nxt = ST_FETCH;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    seed            = 1'b0;
    load_row        = 1'b0;
    fetch           = 1'b0;
    emit            = 1'b0;
    emit_last       = 1'b0;
    q_ctl.clear     = 1'b0;
    q_ctl.push      = 1'b0;
    q_ctl.pop       = 1'b0;
    q_ctl.push_data = col_r;
    unique case (state_r)
      ST_IDLE: begin
        load_row = in_fire && (in_func == FUNC_LOAD);
        seed     = in_fire && (in_func == FUNC_START) && start_ok;
        q_ctl.clear     = seed;
        q_ctl.push      = seed;
        q_ctl.push_data = in_start_node;
      end
      ST_FETCH: begin
        // an empty queue ends the walk: the held node goes out as last
        fetch     = ~q_sts.empty;
        q_ctl.pop = ~q_sts.empty;
        emit      = q_sts.empty;
        emit_last = q_sts.empty;
      end
      ST_SCAN: begin
        q_ctl.push = hit;
        emit       = hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= NODE_COUNT_RST;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_NODES; i++) adj_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (cfg_valid && cfg_ready) node_count_r <= cfg_node_count;
      if (load_row) adj_r[in_row_index] <= in_row_bits;
    end
  end

  // datapath: no reset needed
  always_ff @(posedge clk) begin
    if (emit) begin
      out_visit_node_r <= pend_node_r;
      out_last_r       <= emit_last;
    end
    if (seed) begin
      visited_r   <= ROW_W'(1) << in_start_node;
      pend_node_r <= in_start_node;
    end else if (hit && state_r == ST_SCAN) begin
      visited_r[col_r] <= 1'b1;
      pend_node_r      <= col_r;
    end
    if (fetch) begin
      row_r <= adj_r[q_sts.head_data];
      col_r <= '0;
    end else if (state_r == ST_SCAN) begin
      col_r <= col_r + NODE_W'(1);
    end
  end

  bfs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (q_ctl),
    .sts   (q_sts)
  );

  assign out_valid      = out_valid_r;
  assign out_visit_node = out_visit_node_r;
  assign out_last       = out_last_r;

endmodule

### rtl/core/bfs_queue.sv
// bfs_queue: node FIFO for the traversal, head/tail pointers plus a small
// register store. Depends on bfs_pkg.
`timescale 1ns / 1ps

module bfs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  bfs_pkg::q_ctl_t ctl,
  output bfs_pkg::q_sts_t sts
);
  import bfs_pkg::*;

  logic [NODE_W-1:0] store_r [MAX_NODES];
  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  tail_r;
  logic [PTR_W-1:0]  wr_ptr;

  // a clear with a push seeds entry 0
  assign wr_ptr = ctl.clear ? '0 : tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (ctl.clear) begin
        head_r <= '0;
        tail_r <= ctl.push ? PTR_W'(1) : '0;
      end else begin
        if (ctl.push) tail_r <= tail_r + PTR_W'(1);
        if (ctl.pop)  head_r <= head_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) store_r[wr_ptr[NODE_W-1:0]] <= ctl.push_data;
  end

  assign sts.empty     = (head_r == tail_r);
  assign sts.full      = (tail_r == PTR_W'(MAX_NODES));
  assign sts.head_data = store_r[head_r[NODE_W-1:0]];

endmodule
